// ===== src/res_pkg.sv =====
// Package: shared types, codes and constants of the rumble effect scheduler.
package res_pkg;

	localparam int SLOTS_DEFAULT = 5;
	localparam int CAP_RESET = 1000;
	localparam logic [7:0] FULL_FORCE = 8'd254;
	localparam logic [31:0] STOP_SLACK_MS = 32'd100;
	localparam logic [31:0] DUR_INFINITE = 32'hFFFF_FFFF;
	localparam logic [31:0] ID_RESET = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		REQ_TICK     = 2'd0,
		REQ_START    = 2'd1,
		REQ_STOP     = 2'd2,
		REQ_STOP_ALL = 2'd3
	} req_t;

	typedef enum logic {
		CMD_STOP  = 1'b0,
		CMD_FORCE = 1'b1
	} cmd_t;

	localparam logic CFG_CAP_INFINITE = 1'b0;
	localparam logic CFG_INFINITE_CAP_MS = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] effect_id;
		logic [31:0] start_delay_us;
		logic [31:0] duration_us;
		logic        has_magnitude;
		logic signed [14:0] magnitude;
		logic [1:0]  axis_count;
		logic signed [31:0] first_direction;
		logic signed [31:0] second_direction;
	} req_word_t;

	typedef struct packed {
		logic       command;
		logic [7:0] small_motor;
		logic [7:0] big_motor;
	} rsp_word_t;

	typedef struct packed {
		logic       cfg;
		logic [0:0] index;
		logic [15:0] data;
	} cfg_word_t;

	// Shared-unit operations
	typedef enum logic [2:0] {
		OP_RECIP    = 3'd0,
		OP_ADD      = 3'd1,
		OP_SUB      = 3'd2,
		OP_MUL_MAG  = 3'd3,
		OP_LE       = 3'd4
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] y;
		logic        le;
	} alu_rsp_t;

endpackage

// ===== src/res_if.sv =====
// Interfaces: valid/ready stream channel and configuration write channel.
interface res_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface res_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/rumble_effect_scheduler.sv =====
// Top level of the rumble effect scheduler.
//  channel | dir | payload
//  req     | in  | req_type .. second_direction
//  rsp     | out | command, small_motor, big_motor
//  cfg     | in  | index, data
// The next request is accepted only after the last is done: a start makes two
// reciprocal divides by 1000, a scale multiply and a reciprocal divide by 10000
// in the shared unit, a slot scan and a write; a tick visits each slot, a started
// slot twice, then compares and may emit; a stop scans the slots; a stop-all emits.
// Reset clears the table, clock, sent forces, axis memories and registers.
// An emit waits while the previous result word is still unaccepted.
module rumble_effect_scheduler #(
	parameter int SLOTS = res_pkg::SLOTS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	res_stream_if.sink   req,
	res_stream_if.source rsp,
	res_cfg_if.sink      cfg
);
	logic        cap_infinite;
	logic [15:0] infinite_cap_ms;

	res_cfg u_cfg (.clk, .arst_n, .cfg, .cap_infinite, .infinite_cap_ms);

	res_seq #(.SLOTS(SLOTS)) u_seq (
		.clk, .arst_n,
		.req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
		.cap_infinite, .infinite_cap_ms
	);
endmodule

// ===== src/res_alu.sv =====
// Shared arithmetic unit: add, subtract, compare, reciprocal divide, scale.
module res_alu (
	input  res_pkg::alu_req_t req,
	output res_pkg::alu_rsp_t rsp
);
	logic [32:0] diff;
	logic [63:0] prod;

	always_comb begin
		diff = {1'b0, req.b} - {1'b0, req.a};
		prod = {32'd0, req.a} * {32'd0, req.b};
		rsp.le = ~diff[32];
		unique case (req.op)
			res_pkg::OP_ADD:      rsp.y = req.a + req.b;
			res_pkg::OP_SUB:      rsp.y = req.b - req.a;
			// quotient: a is the pre-shifted dividend, b the reciprocal scaled by 2^36
			res_pkg::OP_RECIP:    rsp.y = {4'd0, prod[63:36]};
			res_pkg::OP_MUL_MAG:  rsp.y = prod[31:0] + 32'd5000;
			res_pkg::OP_LE:       rsp.y = {31'd0, ~diff[32]};
			default:              rsp.y = '0;
		endcase
	end
endmodule

// ===== src/res_seq.sv =====
// Sequencer: decodes a request and walks the slot table through the shared unit.
module res_seq #(
	parameter int SLOTS = res_pkg::SLOTS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  res_pkg::req_word_t   req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output res_pkg::rsp_word_t   rsp_data,
	input  logic                 cap_infinite,
	input  logic [15:0]          infinite_cap_ms
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
	// x/1000 = ((x >> 3) * RECIP_125) >> 36; x/10000 = ((x >> 4) * RECIP_625) >> 36
	localparam logic [31:0] RECIP_125 = 32'd549755814;
	localparam logic [31:0] RECIP_625 = 32'd109951232;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_DIVD   = 12'b000000000010,
		S_DIVU   = 12'b000000000100,
		S_SCALE  = 12'b000000001000,
		S_SCDIV  = 12'b000000010000,
		S_FIND   = 12'b000000100000,
		S_WRITE  = 12'b000001000000,
		S_STOP   = 12'b000010000000,
		S_TICK   = 12'b000100000000,
		S_TICK2  = 12'b001000000000,
		S_TDONE  = 12'b010000000000,
		S_EMIT   = 12'b100000000000
	} state_t;

	state_t state_q;
	res_pkg::req_word_t r_q;
	logic [31:0] now_q;
	logic [31:0] id_q [SLOTS];
	logic [31:0] start_q [SLOTS];
	logic [31:0] stop_q [SLOTS];
	logic [7:0]  fs_q [SLOTS];
	logic [7:0]  fb_q [SLOTS];
	logic [SLOTS-1:0] act_q, strt_q, endl_q;
	logic [7:0]  sent_s_q, sent_b_q, mem_s_q, mem_b_q;
	logic [7:0]  max_s_q, max_b_q, mag_q, emit_s_q, emit_b_q;
	logic [IW-1:0] k_q, idx_q;
	logic        found_q, fnd_id_q;
	logic [31:0] quo_q, dms_q, ums_q;
	logic        out_v_q;
	res_pkg::rsp_word_t out_q;

	res_pkg::alu_req_t au;
	res_pkg::alu_rsp_t ar;
	res_alu u_alu (.req(au), .rsp(ar));

	logic signed [15:0] msat;
	logic [14:0] mpos;
	logic        out_free;

	always_comb begin
		msat = 16'(r_q.magnitude);
		if (msat > 16'sd10000) msat = 16'sd10000;
		if (msat < -16'sd10000) msat = -16'sd10000;
		mpos = 15'(msat + 16'sd10000);
		unique case (state_q)
			S_DIVD:  au = '{op: res_pkg::OP_RECIP, a: {3'd0, r_q.start_delay_us[31:3]},
				b: RECIP_125};
			S_DIVU:  au = '{op: res_pkg::OP_RECIP, a: {3'd0, r_q.duration_us[31:3]},
				b: RECIP_125};
			S_SCALE: au = '{op: res_pkg::OP_MUL_MAG, a: {17'd0, mpos}, b: 32'd127};
			S_SCDIV: au = '{op: res_pkg::OP_RECIP, a: {4'd0, quo_q[31:4]}, b: RECIP_625};
			S_WRITE: au = '{op: res_pkg::OP_ADD, a: now_q, b: dms_q};
			S_TICK:  au = '{op: res_pkg::OP_LE, a: start_q[k_q], b: now_q};
			S_TICK2: au = '{op: res_pkg::OP_LE, a: stop_q[k_q], b: now_q};
			default: au = '{op: res_pkg::OP_ADD, a: '0, b: '0};
		endcase
	end

	assign out_free = !out_v_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_v_q;
	assign rsp_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			r_q <= '0;
			now_q <= '0;
			act_q <= '0; strt_q <= '0; endl_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				id_q[i] <= res_pkg::ID_RESET;
				start_q[i] <= '0; stop_q[i] <= '0;
				fs_q[i] <= '0; fb_q[i] <= '0;
			end
			sent_s_q <= '0; sent_b_q <= '0; mem_s_q <= '0; mem_b_q <= '0;
			max_s_q <= '0; max_b_q <= '0; mag_q <= '0;
			emit_s_q <= '0; emit_b_q <= '0;
			k_q <= '0; idx_q <= '0;
			found_q <= 1'b0; fnd_id_q <= 1'b0;
			quo_q <= '0; dms_q <= '0; ums_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (req_valid && req_ready) begin
					r_q <= req_data;
					k_q <= '0;
					unique case (res_pkg::req_t'(req_data.req_type))
						res_pkg::REQ_TICK: begin
							now_q <= now_q + 32'd1;
							max_s_q <= '0; max_b_q <= '0;
							state_q <= S_TICK;
						end
						res_pkg::REQ_START: state_q <= S_DIVD;
						res_pkg::REQ_STOP: state_q <= S_STOP;
						res_pkg::REQ_STOP_ALL: begin
							act_q <= '0; strt_q <= '0; endl_q <= '0;
							for (int i = 0; i < SLOTS; i++) begin
								id_q[i] <= res_pkg::ID_RESET;
								start_q[i] <= '0; stop_q[i] <= '0;
								fs_q[i] <= '0; fb_q[i] <= '0;
							end
							sent_s_q <= '0; sent_b_q <= '0;
							emit_s_q <= '0; emit_b_q <= '0;
							state_q <= S_EMIT;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_DIVD: begin
					dms_q <= ar.y;
					state_q <= S_DIVU;
				end
				S_DIVU: begin
					ums_q <= ar.y;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					quo_q <= ar.y;
					state_q <= S_SCDIV;
				end
				S_SCDIV: begin
					mag_q <= r_q.has_magnitude ? ar.y[7:0] : res_pkg::FULL_FORCE;
					found_q <= 1'b0; fnd_id_q <= 1'b0;
					state_q <= S_FIND;
				end
				S_FIND: begin
					if (!fnd_id_q && id_q[k_q] == r_q.effect_id) begin
						idx_q <= k_q; fnd_id_q <= 1'b1;
					end else if (!fnd_id_q && !found_q &&
							(!act_q[k_q] || k_q == LAST)) begin
						idx_q <= k_q; found_q <= 1'b1;
					end
					if (k_q == LAST) state_q <= S_WRITE;
					else k_q <= k_q + 1'b1;
				end
				S_WRITE: begin
					id_q[idx_q] <= r_q.effect_id;
					start_q[idx_q] <= ar.y;
					if (r_q.duration_us == res_pkg::DUR_INFINITE) begin
						endl_q[idx_q] <= 1'b1; stop_q[idx_q] <= '0;
					end else begin
						endl_q[idx_q] <= 1'b0; stop_q[idx_q] <= ar.y + ums_q;
					end
					act_q[idx_q] <= 1'b1; strt_q[idx_q] <= 1'b0;
					if (r_q.axis_count == 2'd1) begin
						if (r_q.first_direction == -32'sd1) begin
							mem_s_q <= mag_q; fs_q[idx_q] <= mag_q; fb_q[idx_q] <= mem_b_q;
						end else if (r_q.first_direction == 32'sd1) begin
							mem_b_q <= mag_q; fs_q[idx_q] <= mem_s_q; fb_q[idx_q] <= mag_q;
						end else begin
							fs_q[idx_q] <= mem_s_q; fb_q[idx_q] <= mem_b_q;
						end
					end else if (r_q.axis_count == 2'd0) begin
						// no axes: full force on both motors
						fs_q[idx_q] <= res_pkg::FULL_FORCE;
						fb_q[idx_q] <= res_pkg::FULL_FORCE;
					end else begin
						fs_q[idx_q] <= (r_q.first_direction > 0) ? mag_q : 8'd0;
						fb_q[idx_q] <= (r_q.second_direction > 0) ? mag_q : 8'd0;
					end
					state_q <= S_IDLE;
				end
				S_STOP: begin
					if (id_q[k_q] == r_q.effect_id) begin
						stop_q[k_q] <= '0; endl_q[k_q] <= 1'b0;
					end
					if (k_q == LAST) state_q <= S_IDLE;
					else k_q <= k_q + 1'b1;
				end
				S_TICK: begin
					// started slot: stop compare follows in S_TICK2
					if (act_q[k_q] && strt_q[k_q]) begin
						state_q <= S_TICK2;
					end else begin
						if (act_q[k_q] && ar.le) begin
							strt_q[k_q] <= 1'b1;
							if (!endl_q[k_q]) begin
								stop_q[k_q] <= now_q + ((start_q[k_q] <= stop_q[k_q]) ?
									stop_q[k_q] - start_q[k_q] :
									start_q[k_q] + res_pkg::STOP_SLACK_MS);
							end else if (cap_infinite) begin
								stop_q[k_q] <= now_q + {16'd0, infinite_cap_ms};
								endl_q[k_q] <= 1'b0;
							end
							if (fs_q[k_q] > max_s_q) max_s_q <= fs_q[k_q];
							if (fb_q[k_q] > max_b_q) max_b_q <= fb_q[k_q];
						end
						if (k_q == LAST) state_q <= S_TDONE;
						else k_q <= k_q + 1'b1;
					end
				end
				S_TICK2: begin
					if (!endl_q[k_q] && ar.le) act_q[k_q] <= 1'b0;
					else begin
						if (fs_q[k_q] > max_s_q) max_s_q <= fs_q[k_q];
						if (fb_q[k_q] > max_b_q) max_b_q <= fb_q[k_q];
					end
					if (k_q == LAST) begin
						state_q <= S_TDONE;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_TICK;
					end
				end
				S_TDONE: begin
					// emit only when the pair differs from the last one sent
					if (max_s_q != sent_s_q || max_b_q != sent_b_q) begin
						sent_s_q <= max_s_q; sent_b_q <= max_b_q;
						emit_s_q <= max_s_q; emit_b_q <= max_b_q;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output word: load when free, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_q <= '0;
		end else if (state_q == S_EMIT && out_free) begin
			out_v_q <= 1'b1;
			out_q <= '{command: (emit_s_q == 8'd0 && emit_b_q == 8'd0) ?
				res_pkg::CMD_STOP : res_pkg::CMD_FORCE,
				small_motor: emit_s_q, big_motor: emit_b_q};
		end else if (rsp_ready) begin
			out_v_q <= 1'b0;
		end
	end
endmodule

// ===== src/res_cfg.sv =====
// Configuration registers of the scheduler.
module res_cfg (
	input  logic        clk,
	input  logic        arst_n,
	res_cfg_if.sink     cfg,
	output logic        cap_infinite,
	output logic [15:0] infinite_cap_ms
);
	logic        cap_q;
	logic [15:0] ms_q;
	assign cfg.ready = 1'b1;
	assign cap_infinite = cap_q;
	assign infinite_cap_ms = ms_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 1'b1;
			ms_q <= 16'(res_pkg::CAP_RESET);
		end else if (cfg.valid) begin
			if (cfg.index == res_pkg::CFG_CAP_INFINITE) cap_q <= cfg.data[0];
			else ms_q <= cfg.data;
		end
	end
endmodule

// ===== sim/tb_res_if_note.sv =====
`timescale 1ns / 1ps
// Scoreboard class for the rumble effect scheduler: predicts motor commands and checks them.
class rumble_scoreboard;
	bit        cap_on;
	bit [15:0] cap_ms;
	bit [31:0] clock_ms;
	bit [31:0] id_tab[5];
	bit [31:0] start_tab[5];
	bit [31:0] stop_tab[5];
	bit [7:0]  small_tab[5];
	bit [7:0]  big_tab[5];
	bit        active_tab[5];
	bit        started_tab[5];
	bit        endless_tab[5];
	bit [7:0]  sent_s, sent_b, mem_s, mem_b;
	res_pkg::rsp_word_t pending[$];
	int        errors;

	function new();
		cap_on = 1;
		cap_ms = res_pkg::CAP_RESET;
		clock_ms = 0;
		sent_s = 0; sent_b = 0; mem_s = 0; mem_b = 0;
		errors = 0;
		clear_slots();
	endfunction

	function void clear_slots();
		for (int k = 0; k < 5; k++) begin
			id_tab[k] = res_pkg::ID_RESET;
			start_tab[k] = 0; stop_tab[k] = 0;
			small_tab[k] = 0; big_tab[k] = 0;
			active_tab[k] = 0; started_tab[k] = 0; endless_tab[k] = 0;
		end
	endfunction

	function void set_reg(bit idx, bit [15:0] val);
		if (idx == res_pkg::CFG_CAP_INFINITE) cap_on = val[0];
		else cap_ms = val;
	endfunction

	function bit [7:0] mag_force(logic signed [14:0] raw);
		int m;
		m = raw;
		if (m > 10000) m = 10000;
		if (m < -10000) m = -10000;
		return 8'(((m + 10000) * 127 + 5000) / 10000);
	endfunction

	function void push_cmd(bit [7:0] s, bit [7:0] b);
		res_pkg::rsp_word_t w;
		w.command = (s == 0 && b == 0) ? res_pkg::CMD_STOP : res_pkg::CMD_FORCE;
		w.small_motor = s;
		w.big_motor = b;
		pending.push_back(w);
	endfunction

	function void note_request(res_pkg::req_word_t r);
		int idx;
		bit [7:0] mag, fs, fb;
		bit [1:0] axes;
		bit live;
		bit [31:0] dt;
		idx = -1;
		case (r.req_type)
			res_pkg::REQ_TICK: begin
				clock_ms++;
				fs = 0; fb = 0;
				for (int k = 0; k < 5; k++) begin
					live = 0;
					if (active_tab[k]) begin
						if (started_tab[k]) begin
							if (!endless_tab[k] && stop_tab[k] <= clock_ms) active_tab[k] = 0;
							else live = 1;
						end else if (start_tab[k] <= clock_ms) begin
							started_tab[k] = 1;
							if (!endless_tab[k]) begin
								dt = (start_tab[k] <= stop_tab[k]) ? stop_tab[k] - start_tab[k]
									: start_tab[k] + res_pkg::STOP_SLACK_MS;
								stop_tab[k] = clock_ms + dt;
							end else if (cap_on) begin
								stop_tab[k] = clock_ms + cap_ms;
								endless_tab[k] = 0;
							end
							live = 1;
						end
						if (live) begin
							if (small_tab[k] > fs) fs = small_tab[k];
							if (big_tab[k] > fb) fb = big_tab[k];
						end
					end
				end
				if (fs != sent_s || fb != sent_b) begin
					sent_s = fs; sent_b = fb;
					push_cmd(fs, fb);
				end
			end
			res_pkg::REQ_START: begin
				mag = r.has_magnitude ? mag_force(r.magnitude) : res_pkg::FULL_FORCE;
				axes = (r.axis_count == 3) ? 2'd2 : r.axis_count;
				for (int k = 0; k < 5; k++)
					if (idx < 0 && id_tab[k] == r.effect_id) idx = k;
				for (int k = 0; k < 5; k++)
					if (idx < 0 && (!active_tab[k] || k == 4)) idx = k;
				fs = res_pkg::FULL_FORCE; fb = res_pkg::FULL_FORCE;
				if (axes == 1) begin
					if (r.first_direction == -1) mem_s = mag;
					else if (r.first_direction == 1) mem_b = mag;
					fs = mem_s; fb = mem_b;
				end else if (axes == 2) begin
					fs = (r.first_direction > 0) ? mag : 8'd0;
					fb = (r.second_direction > 0) ? mag : 8'd0;
				end
				small_tab[idx] = fs; big_tab[idx] = fb;
				id_tab[idx] = r.effect_id;
				start_tab[idx] = clock_ms + r.start_delay_us / 1000;
				if (r.duration_us == res_pkg::DUR_INFINITE) begin
					endless_tab[idx] = 1; stop_tab[idx] = 0;
				end else begin
					endless_tab[idx] = 0;
					stop_tab[idx] = start_tab[idx] + r.duration_us / 1000;
				end
				active_tab[idx] = 1; started_tab[idx] = 0;
			end
			res_pkg::REQ_STOP: begin
				for (int k = 0; k < 5; k++)
					if (id_tab[k] == r.effect_id) begin
						stop_tab[k] = 0; endless_tab[k] = 0;
					end
			end
			default: begin
				clear_slots();
				sent_s = 0; sent_b = 0;
				push_cmd(0, 0);
			end
		endcase
	endfunction

	function void check_command(res_pkg::rsp_word_t got);
		res_pkg::rsp_word_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected command exp none act %h", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.command !== want.command) begin
			$display("%0t: command exp %0d act %0d", $time, want.command, got.command);
			errors++;
		end
		if (got.small_motor !== want.small_motor) begin
			$display("%0t: small_motor exp %0d act %0d", $time, want.small_motor,
				got.small_motor);
			errors++;
		end
		if (got.big_motor !== want.big_motor) begin
			$display("%0t: big_motor exp %0d act %0d", $time, want.big_motor, got.big_motor);
			errors++;
		end
	endfunction
endclass

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top: drives requests and register writes into the rumble effect scheduler.
module tb_top;
	localparam int REQ_W = $bits(res_pkg::req_word_t);
	localparam int RSP_W = $bits(res_pkg::rsp_word_t);
	localparam int IDLE_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	res_stream_if #(.W(REQ_W)) req ();
	res_stream_if #(.W(RSP_W)) rsp ();
	res_cfg_if cfg ();

	rumble_scoreboard sb = new();
	bit quiet_rx = 0;
	bit hold_rx = 0;
	int stall_pct = 29;
	int idle_cycles = 0;

	rumble_effect_scheduler dut (.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg(cfg.sink));

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		req.valid = 0; req.data = '0;
		rsp.ready = 0;
		cfg.valid = 0; cfg.index = '0; cfg.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
	end

	// receiver side: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready) sb.check_command(res_pkg::rsp_word_t'(rsp.data));
			rsp.ready <= !hold_rx && (quiet_rx || $urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("FAIL rumble_effect_scheduler");
			$finish;
		end
	end

	task automatic send_word(res_pkg::req_word_t w, bit gaps);
		if (gaps && $urandom_range(99) < 29) begin
			// drop valid for a random idle stretch
			req.valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < 29);
		end
		req.valid <= 1;
		req.data <= w;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.note_request(w);
	endtask

	task automatic write_reg(bit idx, bit [15:0] val);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.set_reg(idx, val);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		req.valid <= 0;
		while (sb.pending.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		// a tick or stop may still be walking the slots with no result due
		repeat (150) @(posedge clk);
	endtask

	function automatic res_pkg::req_word_t tick_word();
		res_pkg::req_word_t w;
		w = '0;
		w.req_type = res_pkg::REQ_TICK;
		return w;
	endfunction

	function automatic res_pkg::req_word_t any_word();
		logic [191:0] bits_all;
		bits_all = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return res_pkg::req_word_t'(bits_all[REQ_W-1:0]);
	endfunction

	// mostly well formed: small ids, short times, ticks dominate
	function automatic res_pkg::req_word_t rand_word();
		res_pkg::req_word_t w;
		int pick;
		w = any_word();
		pick = $urandom_range(99);
		if (pick < 3) return w;
		w.effect_id = $urandom_range(7);
		if ($urandom_range(9) == 0) w.effect_id = $urandom;
		w.start_delay_us = $urandom_range(30000);
		w.duration_us = ($urandom_range(7) == 0) ? res_pkg::DUR_INFINITE : $urandom_range(80000);
		w.magnitude = 15'($urandom_range(20000) - 10000);
		if ($urandom_range(3) == 0) w.first_direction = $urandom_range(2) - 1;
		if ($urandom_range(3) == 0) w.second_direction = $urandom_range(2) - 1;
		if (pick < 70) w.req_type = res_pkg::REQ_TICK;
		else if (pick < 88) w.req_type = res_pkg::REQ_START;
		else if (pick < 98) w.req_type = res_pkg::REQ_STOP;
		else w.req_type = res_pkg::REQ_STOP_ALL;
		return w;
	endfunction

	initial begin
		res_pkg::req_word_t w;
		@(posedge arst_n);
		@(posedge clk);
		write_reg(res_pkg::CFG_CAP_INFINITE, 16'd1);
		write_reg(res_pkg::CFG_INFINITE_CAP_MS, 16'd3);
		// directed: extremes of magnitude, axis forms, infinite and wrapped times
		w = any_word(); w.req_type = res_pkg::REQ_START; w.effect_id = 32'hFFFF_FFFF;
		w.start_delay_us = 0; w.duration_us = res_pkg::DUR_INFINITE; w.axis_count = 2'd0;
		w.has_magnitude = 1; w.magnitude = 15'sh4000; send_word(w, 0);
		w.effect_id = 1; w.axis_count = 2'd1; w.first_direction = -1;
		w.magnitude = 15'sh3FFF; w.duration_us = 5000; send_word(w, 0);
		w.effect_id = 2; w.first_direction = 1; w.magnitude = -15'sd10000;
		w.has_magnitude = 0; send_word(w, 0);
		w.effect_id = 3; w.first_direction = 7; send_word(w, 0);
		w.effect_id = 4; w.axis_count = 2'd3; w.first_direction = 32'sh7FFF_FFFF;
		w.second_direction = 32'sh8000_0000; w.has_magnitude = 1; w.magnitude = 15'sd10000;
		send_word(w, 0);
		w.effect_id = 5; w.axis_count = 2'd2; w.first_direction = 0; w.second_direction = 9;
		w.start_delay_us = 32'hFFFF_FFFF; w.duration_us = 32'hFFFF_FFFE; send_word(w, 0);
		for (int i = 0; i < 8; i++) send_word(tick_word(), 0);
		w.req_type = res_pkg::REQ_STOP; w.effect_id = 1; send_word(w, 0);
		w.effect_id = 32'hFFFF_FFFF; send_word(w, 0);
		send_word(tick_word(), 0);
		w.req_type = res_pkg::REQ_STOP_ALL; send_word(w, 0);
		drain();
		// phases through register settings; phase 2 has no idling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(res_pkg::CFG_CAP_INFINITE, 16'd0);
					write_reg(res_pkg::CFG_INFINITE_CAP_MS, 16'd0);
				end
				1: begin
					write_reg(res_pkg::CFG_CAP_INFINITE, 16'hFFFF);
					write_reg(res_pkg::CFG_INFINITE_CAP_MS, 16'hFFFF);
				end
				2: begin
					write_reg(res_pkg::CFG_CAP_INFINITE, 16'd1);
					write_reg(res_pkg::CFG_INFINITE_CAP_MS, 16'd40);
				end
				default: begin
					write_reg(res_pkg::CFG_CAP_INFINITE, 16'd1);
					write_reg(res_pkg::CFG_INFINITE_CAP_MS, 16'($urandom));
				end
			endcase
			quiet_rx = (ph == 2);
			for (int i = 0; i < 400; i++) begin
				if (ph == 1 && i == 100) begin
					// hold off the receiver while requests keep coming
					fork
						begin
							hold_rx = 1;
							repeat (3000) @(posedge clk);
							hold_rx = 0;
						end
					join_none
				end
				if (ph == 3 && i == 200) drain();
				w = rand_word();
				if (ph == 1 && i >= 100 && i < 140) begin
					w = tick_word();
					if (i % 2 == 0) w.req_type = res_pkg::REQ_STOP_ALL;
				end
				send_word(w, ph != 2);
			end
			drain();
		end
		if (sb.pending.size() != 0) sb.errors++;
		if (sb.errors == 0)
			$display("PASS rumble_effect_scheduler");
		else
			$display("FAIL rumble_effect_scheduler");
		$finish;
	end
endmodule
